// ----- rtl/smbe_pkg.sv -----
// Shared types and constants for the SPI master bit engine.
package smbe_pkg;

   // Width of the bit count field on the request channel.
   localparam int CNT_W = 6;

   // CSR data and address widths.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // Sequencer phases: pre wait, four steps per bit, post wait.
   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_PRE  = 4'd1,
      PH_A    = 4'd2,
      PH_B    = 4'd3,
      PH_C    = 4'd4,
      PH_D    = 4'd5,
      PH_POST = 4'd6
   } phase_type;

   // CSR register indexes (byte address = 4 * index).
   typedef enum logic [2:0] {
      REG_POLARITY = 3'd0,
      REG_PHASE    = 3'd1,
      REG_PRE      = 3'd2,
      REG_POST     = 3'd3,
      REG_SAMPLE   = 3'd4,
      REG_SETTLE   = 3'd5
   } reg_index_type;

   // Indexes into the packed array of wait lengths.
   localparam int WAIT_PRE    = 0;
   localparam int WAIT_POST   = 1;
   localparam int WAIT_SAMPLE = 2;
   localparam int WAIT_SETTLE = 3;
   localparam int WAIT_COUNT  = 4;

   // Clock mode bits handed from the CSR block to the sequencer.
   typedef struct packed {
      logic polarity;
      logic phase;
   } mode_type;

endpackage

// ----- rtl/smbe_req_if.sv -----
// Request channel interface: one timing tick per transfer.
interface smbe_req_if
   import smbe_pkg::*;
#(
   parameter int WORD_BITS = 32
);
   logic                 valid;
   logic                 ready;
   logic                 start_req;
   logic [WORD_BITS-1:0] tx_word;
   logic [CNT_W-1:0]     xfer_bits;
   logic                 miso_level;

   modport source (output valid, start_req, tx_word, xfer_bits, miso_level, input ready);
   modport sink   (input valid, start_req, tx_word, xfer_bits, miso_level, output ready);
endinterface

// ----- rtl/smbe_rsp_if.sv -----
// Response channel interface: pin levels and status for one tick.
interface smbe_rsp_if #(
   parameter int WORD_BITS = 32
);
   logic                 valid;
   logic                 ready;
   logic                 sck_level;
   logic                 mosi_level;
   logic                 busy_res;
   logic                 done_res;
   logic [WORD_BITS-1:0] rx_word;

   modport source (output valid, sck_level, mosi_level, busy_res, done_res, rx_word,
                   input ready);
   modport sink   (input valid, sck_level, mosi_level, busy_res, done_res, rx_word,
                   output ready);
endinterface

// ----- rtl/smbe_csr.sv -----
// APB-style configuration registers for the SPI master bit engine.
module smbe_csr
   import smbe_pkg::*;
#(
   parameter int WAIT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [CSR_ADDR_W-1:0]                 paddr,
   input  logic [CSR_DATA_W-1:0]                 pwdata,
   output logic [CSR_DATA_W-1:0]                 prdata,
   output logic                                  pready,
   output mode_type                              mode,
   output logic [WAIT_COUNT-1:0][WAIT_BITS-1:0]  waits
);

   mode_type                             mode_ff, mode_in;
   logic [WAIT_COUNT-1:0][WAIT_BITS-1:0] waits_ff, waits_in;
   reg_index_type                        idx;
   logic                                 wr_en;

   assign idx   = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      mode_in  = mode_ff;
      waits_in = waits_ff;
      if (wr_en) begin
         case (idx)
            REG_POLARITY: mode_in.polarity          = pwdata[0];
            REG_PHASE:    mode_in.phase             = pwdata[0];
            REG_PRE:      waits_in[WAIT_PRE]        = pwdata[WAIT_BITS-1:0];
            REG_POST:     waits_in[WAIT_POST]       = pwdata[WAIT_BITS-1:0];
            REG_SAMPLE:   waits_in[WAIT_SAMPLE]     = pwdata[WAIT_BITS-1:0];
            REG_SETTLE:   waits_in[WAIT_SETTLE]     = pwdata[WAIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_POLARITY: prdata = CSR_DATA_W'(mode_ff.polarity);
         REG_PHASE:    prdata = CSR_DATA_W'(mode_ff.phase);
         REG_PRE:      prdata = CSR_DATA_W'(waits_ff[WAIT_PRE]);
         REG_POST:     prdata = CSR_DATA_W'(waits_ff[WAIT_POST]);
         REG_SAMPLE:   prdata = CSR_DATA_W'(waits_ff[WAIT_SAMPLE]);
         REG_SETTLE:   prdata = CSR_DATA_W'(waits_ff[WAIT_SETTLE]);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         waits_ff <= {WAIT_COUNT{WAIT_BITS'(1)}};
      end else begin
         mode_ff  <= mode_in;
         waits_ff <= waits_in;
      end
   end

   assign mode  = mode_ff;
   assign waits = waits_ff;

endmodule

// ----- rtl/smbe_core.sv -----
// Phase sequencer and shift registers: one step per accepted tick.
module smbe_core
   import smbe_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int WAIT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic                                  start_req,
   input  logic [WORD_BITS-1:0]                  tx_word,
   input  logic [CNT_W-1:0]                      xfer_bits,
   input  logic                                  miso_level,
   input  mode_type                              mode,
   input  logic [WAIT_COUNT-1:0][WAIT_BITS-1:0]  waits,
   output logic                                  sck_level,
   output logic                                  mosi_level,
   output logic                                  busy_res,
   output logic                                  done_res,
   output logic [WORD_BITS-1:0]                  rx_word
);

   localparam int IDX_W = $clog2(WORD_BITS);

   phase_type            phase_ff, phase_in;
   logic [WAIT_BITS-1:0] wait_ff, wait_in, wait_dec;
   logic [CNT_W-1:0]     bit_index_ff, bit_index_in;
   logic [CNT_W-1:0]     bits_total_ff, bits_total_in;
   logic [WORD_BITS-1:0] tx_ff, tx_in;
   logic [WORD_BITS-1:0] rx_ff, rx_in;
   logic                 sck_ff, sck_in;
   logic                 mosi_ff, mosi_in;
   logic                 expire;
   logic                 done;
   logic [WAIT_BITS-1:0] eff_pre, eff_post, eff_sample, eff_settle;
   logic                 cur_bit;

   // A zero wait counts as one tick.
   assign eff_pre    = (waits[WAIT_PRE] == '0)    ? WAIT_BITS'(1) : waits[WAIT_PRE];
   assign eff_post   = (waits[WAIT_POST] == '0)   ? WAIT_BITS'(1) : waits[WAIT_POST];
   assign eff_sample = (waits[WAIT_SAMPLE] == '0) ? WAIT_BITS'(1) : waits[WAIT_SAMPLE];
   assign eff_settle = (waits[WAIT_SETTLE] == '0) ? WAIT_BITS'(1) : waits[WAIT_SETTLE];

   assign wait_dec = (wait_ff != '0) ? wait_ff - WAIT_BITS'(1) : wait_ff;
   assign expire   = (phase_ff != PH_IDLE) && (wait_dec == '0);

   // Advance the bit index when leaving the last step of a bit.
   assign bit_index_in = (expire && phase_ff == PH_D) ? bit_index_ff + CNT_W'(1)
                                                      : bit_index_ff;
   assign cur_bit = tx_ff[bit_index_in[IDX_W-1:0]];

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (phase_ff == PH_IDLE) begin
         if (start_req) begin
            phase_in = PH_PRE;
         end
      end else if (expire) begin
         case (phase_ff)
            PH_PRE:  phase_in = (bits_total_ff != '0) ? PH_A : PH_POST;
            PH_A:    phase_in = PH_B;
            PH_B:    phase_in = PH_C;
            PH_C:    phase_in = PH_D;
            PH_D:    phase_in = (bit_index_in < bits_total_ff) ? PH_A : PH_POST;
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // Datapath actions on phase entry.
   always_comb begin
      wait_in       = wait_ff;
      bits_total_in = bits_total_ff;
      tx_in         = tx_ff;
      rx_in         = rx_ff;
      sck_in        = sck_ff;
      mosi_in       = mosi_ff;
      done          = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (start_req) begin
            tx_in         = tx_word;
            bits_total_in = (int'(xfer_bits) > WORD_BITS) ? CNT_W'(WORD_BITS) : xfer_bits;
            rx_in         = '0;
            mosi_in       = 1'b0;
            sck_in        = 1'b0;
            wait_in       = eff_pre;
         end
      end else begin
         wait_in = wait_dec;
         if (expire) begin
            case (phase_in)
               PH_A: begin
                  if (mode.phase) begin
                     sck_in = 1'b1; wait_in = eff_sample;
                  end else begin
                     mosi_in = cur_bit; wait_in = eff_settle;
                  end
               end
               PH_B: begin
                  if (mode.phase) begin
                     mosi_in = cur_bit; wait_in = eff_settle;
                  end else begin
                     sck_in = 1'b1; wait_in = eff_sample;
                  end
               end
               PH_C: begin
                  if (mode.phase) begin
                     sck_in = 1'b0; wait_in = eff_sample;
                  end else begin
                     rx_in = {rx_ff[WORD_BITS-2:0], miso_level}; wait_in = eff_settle;
                  end
               end
               PH_D: begin
                  if (mode.phase) begin
                     rx_in = {rx_ff[WORD_BITS-2:0], miso_level}; wait_in = eff_settle;
                  end else begin
                     sck_in = 1'b0; wait_in = eff_sample;
                  end
               end
               PH_POST: begin
                  mosi_in = 1'b0;
                  wait_in = eff_post;
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         wait_ff       <= '0;
         bit_index_ff  <= '0;
         bits_total_ff <= '0;
         tx_ff         <= '0;
         rx_ff         <= '0;
         sck_ff        <= 1'b0;
         mosi_ff       <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         wait_ff       <= wait_in;
         bit_index_ff  <= (phase_ff == PH_IDLE) ? '0 : bit_index_in;
         bits_total_ff <= bits_total_in;
         tx_ff         <= tx_in;
         rx_ff         <= rx_in;
         sck_ff        <= sck_in;
         mosi_ff       <= mosi_in;
      end
   end

   assign sck_level  = sck_in ^ mode.polarity;
   assign mosi_level = mosi_in;
   assign busy_res   = (phase_in != PH_IDLE);
   assign done_res   = done;
   assign rx_word    = done ? rx_in : '0;

endmodule

// ----- rtl/spi_master_bit_engine_top.sv -----
// Top level of the tick-driven SPI master bit engine.
//
//  channel   direction  handshake          content
//  req_chan  in         valid/ready        start_req, tx_word, xfer_bits, miso_level
//  rsp_chan  out        valid/ready        sck_level, mosi_level, busy_res, done_res, rx_word
//  csr       in         psel/penable/pwrite  six config registers at 4*index
//
// One request transfer is taken every cycle while ready is high; its response is registered.
// The sequencer step is a short path from the phase/counter registers to the result
// register, so throughput is one tick per clock, limited only by the response side.
// A two-entry output buffer (result register plus skid) keeps req_chan.ready high
// while one response waits; ready drops only when both entries are full.
// Reset is synchronous, active high; the config registers return to their defaults.
module spi_master_bit_engine_top
   import smbe_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int WAIT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   smbe_req_if.sink              req_chan,
   smbe_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int RES_W = WORD_BITS + 4;

   mode_type                             mode;
   logic [WAIT_COUNT-1:0][WAIT_BITS-1:0] waits;
   logic                                 accept;
   logic                                 pop;
   logic                                 core_sck, core_mosi, core_busy, core_done;
   logic [WORD_BITS-1:0]                 core_rx;
   logic [RES_W-1:0]                     result;

   // Output buffer: head register drives the port, skid holds the overflow.
   logic             out_valid_ff, out_valid_in;
   logic [RES_W-1:0] out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [RES_W-1:0] skid_data_ff, skid_data_in;

   smbe_csr #(
      .WAIT_BITS (WAIT_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .mode    (mode),
      .waits   (waits)
   );

   // Take a tick whenever the skid entry is free.
   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   smbe_core #(
      .WORD_BITS (WORD_BITS),
      .WAIT_BITS (WAIT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .start_req  (req_chan.start_req),
      .tx_word    (req_chan.tx_word),
      .xfer_bits  (req_chan.xfer_bits),
      .miso_level (req_chan.miso_level),
      .mode       (mode),
      .waits      (waits),
      .sck_level  (core_sck),
      .mosi_level (core_mosi),
      .busy_res   (core_busy),
      .done_res   (core_done),
      .rx_word    (core_rx)
   );

   assign result = {core_sck, core_mosi, core_busy, core_done, core_rx};

   // Buffer control: load the head when it is empty or drains, else park in skid.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.sck_level  = out_data_ff[RES_W-1];
   assign rsp_chan.mosi_level = out_data_ff[RES_W-2];
   assign rsp_chan.busy_res   = out_data_ff[RES_W-3];
   assign rsp_chan.done_res   = out_data_ff[RES_W-4];
   assign rsp_chan.rx_word    = out_data_ff[WORD_BITS-1:0];

   // The skid entry is only ever filled behind a full head.
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty head");

   // The done tick always reports the engine as no longer busy.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.done_res |-> !rsp_chan.busy_res)
      else $error("done reported while busy");

   // Received data shows only on the done tick.
   a_rx_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.done_res |-> rsp_chan.rx_word == '0)
      else $error("rx_word nonzero outside done");

   // A start taken while the engine is idle makes that tick's result busy.
   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.start_req && (u_core.phase_ff == PH_IDLE) |-> core_busy)
      else $error("start did not begin a transfer");

endmodule

// ----- verif/smbe_tick_checker.sv -----
// Scoreboard for the SPI master bit engine: tick-level prediction and result compare.
`timescale 1ns / 1ps

module smbe_tick_checker
   import smbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   smbe_req_if                   req_mon,
   smbe_rsp_if                   rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    mismatch_count,
   output int                    pending_count
);

   localparam int WORD_W = 32;
   localparam int WAIT_W = 16;
   localparam int POS_W  = $clog2(WORD_W);

   typedef struct packed {
      logic              sck_level;
      logic              mosi_level;
      logic              busy_res;
      logic              done_res;
      logic [WORD_W-1:0] rx_word;
   } pin_state_type;

   // Register shadow.
   logic              cfg_polarity;
   logic              cfg_phase;
   logic [WAIT_W-1:0] cfg_pre;
   logic [WAIT_W-1:0] cfg_post;
   logic [WAIT_W-1:0] cfg_sample;
   logic [WAIT_W-1:0] cfg_settle;

   // Sequencer state of the predictor.
   phase_type         seq_phase;
   logic [WAIT_W-1:0] wait_left;
   logic [CNT_W-1:0]  bit_pos;
   logic [CNT_W-1:0]  bit_limit;
   logic [WORD_W-1:0] tx_bits;
   logic [WORD_W-1:0] rx_bits;
   logic              sck_q;
   logic              mosi_q;

   pin_state_type pending_pin_states[$];

   // A programmed wait of zero still lasts one tick.
   function automatic logic [WAIT_W-1:0] wait_len(input logic [WAIT_W-1:0] d);
      return (d == '0) ? WAIT_W'(1) : d;
   endfunction

   // Perform the action that opens a step and load its wait.
   function automatic void open_step(input phase_type ph, input logic miso);
      seq_phase = ph;
      case (ph)
         PH_A: begin
            if (cfg_phase) begin
               sck_q     = 1'b1;
               wait_left = wait_len(cfg_sample);
            end else begin
               mosi_q    = tx_bits[bit_pos[POS_W-1:0]];
               wait_left = wait_len(cfg_settle);
            end
         end
         PH_B: begin
            if (cfg_phase) begin
               mosi_q    = tx_bits[bit_pos[POS_W-1:0]];
               wait_left = wait_len(cfg_settle);
            end else begin
               sck_q     = 1'b1;
               wait_left = wait_len(cfg_sample);
            end
         end
         PH_C: begin
            if (cfg_phase) begin
               sck_q     = 1'b0;
               wait_left = wait_len(cfg_sample);
            end else begin
               rx_bits   = {rx_bits[WORD_W-2:0], miso};
               wait_left = wait_len(cfg_settle);
            end
         end
         PH_D: begin
            if (cfg_phase) begin
               rx_bits   = {rx_bits[WORD_W-2:0], miso};
               wait_left = wait_len(cfg_settle);
            end else begin
               sck_q     = 1'b0;
               wait_left = wait_len(cfg_sample);
            end
         end
         default: begin
            seq_phase = PH_POST;
            mosi_q    = 1'b0;
            wait_left = wait_len(cfg_post);
         end
      endcase
   endfunction

   // Advance the engine by one tick and return the pin levels of that tick.
   function automatic pin_state_type advance_bit_engine(input logic start,
                                                        input logic [WORD_W-1:0] word,
                                                        input logic [CNT_W-1:0] count,
                                                        input logic miso);
      pin_state_type pins;
      logic          done_now;
      done_now = 1'b0;
      if (seq_phase == PH_IDLE) begin
         if (start) begin
            tx_bits   = word;
            bit_limit = (count > CNT_W'(WORD_W)) ? CNT_W'(WORD_W) : count;
            bit_pos   = '0;
            rx_bits   = '0;
            mosi_q    = 1'b0;
            sck_q     = 1'b0;
            seq_phase = PH_PRE;
            wait_left = wait_len(cfg_pre);
         end
      end else begin
         if (wait_left != '0) wait_left = wait_left - WAIT_W'(1);
         if (wait_left == '0) begin
            case (seq_phase)
               PH_PRE: open_step((bit_limit != '0) ? PH_A : PH_POST, miso);
               PH_A:   open_step(PH_B, miso);
               PH_B:   open_step(PH_C, miso);
               PH_C:   open_step(PH_D, miso);
               PH_D: begin
                  bit_pos = bit_pos + CNT_W'(1);
                  open_step((bit_pos < bit_limit) ? PH_A : PH_POST, miso);
               end
               default: begin
                  seq_phase = PH_IDLE;
                  done_now  = 1'b1;
               end
            endcase
         end
      end
      pins.sck_level  = sck_q ^ cfg_polarity;
      pins.mosi_level = mosi_q;
      pins.busy_res   = (seq_phase != PH_IDLE);
      pins.done_res   = done_now;
      pins.rx_word    = done_now ? rx_bits : '0;
      return pins;
   endfunction

   function automatic void check_field(input string field, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      pin_state_type want;
      if (reset) begin
         cfg_polarity = 1'b0;
         cfg_phase    = 1'b0;
         cfg_pre      = WAIT_W'(1);
         cfg_post     = WAIT_W'(1);
         cfg_sample   = WAIT_W'(1);
         cfg_settle   = WAIT_W'(1);
         seq_phase    = PH_IDLE;
         wait_left    = '0;
         bit_pos      = '0;
         bit_limit    = '0;
         tx_bits      = '0;
         rx_bits      = '0;
         sck_q        = 1'b0;
         mosi_q       = 1'b0;
         pending_pin_states.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_POLARITY: cfg_polarity = pwdata[0];
               REG_PHASE:    cfg_phase    = pwdata[0];
               REG_PRE:      cfg_pre      = pwdata[WAIT_W-1:0];
               REG_POST:     cfg_post     = pwdata[WAIT_W-1:0];
               REG_SAMPLE:   cfg_sample   = pwdata[WAIT_W-1:0];
               REG_SETTLE:   cfg_settle   = pwdata[WAIT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_pin_states.size() == 0) begin
               $error("result transfer with no prediction waiting");
               mismatch_count++;
            end else begin
               want = pending_pin_states.pop_front();
               check_field("sck_level", WORD_W'(want.sck_level), WORD_W'(rsp_mon.sck_level));
               check_field("mosi_level", WORD_W'(want.mosi_level),
                           WORD_W'(rsp_mon.mosi_level));
               check_field("busy_res", WORD_W'(want.busy_res), WORD_W'(rsp_mon.busy_res));
               check_field("done_res", WORD_W'(want.done_res), WORD_W'(rsp_mon.done_res));
               check_field("rx_word", want.rx_word, rsp_mon.rx_word);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_pin_states.push_back(advance_bit_engine(req_mon.start_req,
                                                            req_mon.tx_word,
                                                            req_mon.xfer_bits,
                                                            req_mon.miso_level));
         end
      end
      pending_count = pending_pin_states.size();
   end

endmodule

// ----- verif/tb_spi_master_bit_engine_top.sv -----
// Top-level testbench for the SPI master bit engine: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_spi_master_bit_engine_top;
   import smbe_pkg::*;

   // Watchdog limit for a run with heavy idling and stalls, the long hold-off
   // and the register writes.
   localparam int CYCLE_LIMIT = 100_000;
   // Length of the one long receiver hold-off.
   localparam int HOLD_CYCLES = 200;
   // Minimum ticks sent per flow-control phase.
   localparam int PHASE_TICKS = 70;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   smbe_req_if req_chan ();
   smbe_rsp_if rsp_chan ();

   // Flow-control knobs, owned by the stimulus process.
   int send_idle_pct;
   int stall_pct;
   bit hold_armed;
   // Set by the receiver process once it has taken the hold-off.
   bit hold_taken;

   // Handshake bookkeeping used to pace stimulus.
   int unsigned req_taken;
   int unsigned rsp_taken;
   int unsigned done_seen;

   int mismatch_count;
   int pending_count;

   spi_master_bit_engine_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   smbe_tick_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 4 ns clock: high for 2, low for 2.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Count transfers on both channels at the rising edge. A transfer on the
   // result side that carries done marks the end of one SPI transaction.
   always @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) req_taken++;
      if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_taken++;
         if (rsp_chan.done_res) done_seen++;
      end
   end

   // Receiver: drop ready at random per stall_pct. Once armed, hold ready low
   // for a long stretch so the output buffer fills and req_chan.ready drops
   // while the sender keeps offering ticks.
   initial begin : receiver
      hold_taken     = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one tick, with random idle cycles first, and hold it until the
   // block takes it. Enter and leave at a falling edge.
   task automatic push_tick(input logic s, input logic [31:0] w, input logic [CNT_W-1:0] c,
                            input logic m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.start_req  <= s;
      req_chan.tx_word    <= w;
      req_chan.xfer_bits  <= c;
      req_chan.miso_level <= m;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Keep ticking until the done count reaches goal. With noise on, some
   // ticks also carry a start, which the busy engine must ignore.
   task automatic wait_done(input int unsigned goal, input bit noisy);
      logic s;
      while (done_seen < goal) begin
         s = noisy ? ($urandom_range(3) == 0) : 1'b0;
         push_tick(s, $urandom, CNT_W'($urandom_range(63)), 1'($urandom_range(1)));
      end
   endtask

   // Issue a start and run the SPI transaction to its done tick.
   task automatic run_transfer(input logic [31:0] w, input logic [CNT_W-1:0] c,
                               input bit noisy);
      int unsigned goal;
      goal = done_seen + 1;
      push_tick(1'b1, w, c, 1'($urandom_range(1)));
      wait_done(goal, noisy);
   endtask

   // Drop valid and drain: wait until every tick sent has its result back,
   // then let the pipeline go quiet before touching a register.
   task automatic settle_down();
      req_chan.valid <= 1'b0;
      while (req_taken != rsp_taken) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write: setup cycle, access cycle, then release the bus.
   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_waits(input logic [CSR_DATA_W-1:0] pre, input logic [CSR_DATA_W-1:0] post,
                              input logic [CSR_DATA_W-1:0] smp,
                              input logic [CSR_DATA_W-1:0] stl);
      write_reg(REG_PRE, pre);
      write_reg(REG_POST, post);
      write_reg(REG_SAMPLE, smp);
      write_reg(REG_SETTLE, stl);
   endtask

   // Short waits most of the time so that many transactions fit in the run.
   function automatic logic [CSR_DATA_W-1:0] pick_wait();
      return ($urandom_range(9) == 0) ? CSR_DATA_W'($urandom_range(8))
                                      : CSR_DATA_W'($urandom_range(2));
   endfunction

   // Mostly short transactions, some longer up to a full word, a few oversized counts.
   function automatic logic [CNT_W-1:0] pick_count();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return CNT_W'($urandom_range(6));
      else if (r < 90) return CNT_W'($urandom_range(32, 7));
      else return CNT_W'($urandom_range(63, 33));
   endfunction

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int unsigned goal;
      int unsigned base;
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_chan.valid      = 1'b0;
      req_chan.start_req  = 1'b0;
      req_chan.tx_word    = '0;
      req_chan.xfer_bits  = '0;
      req_chan.miso_level = 1'b0;
      send_idle_pct       = 0;
      stall_pct           = 0;
      hold_armed          = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, reset settings: zero count (pre wait straight into
      // post), single bit, then a word of ones with a count past the word
      // width that must saturate.
      run_transfer(32'h0000_0000, CNT_W'(0), 1'b0);
      run_transfer(32'h0000_0001, CNT_W'(1), 1'b0);
      run_transfer(32'hFFFF_FFFF, CNT_W'(63), 1'b0);

      // Idle-high clock, data after the leading edge, every wait at zero
      // (treated as one tick).
      settle_down();
      write_reg(REG_POLARITY, CSR_DATA_W'(1));
      write_reg(REG_PHASE, CSR_DATA_W'(1));
      write_waits('0, '0, '0, '0);
      run_transfer(32'hA5A5_A5A5, CNT_W'(12), 1'b0);
      run_transfer($urandom, CNT_W'(5), 1'b1);

      // Switch polarity, phase and sample wait in the middle of a transaction;
      // the busy ticks before it also carry starts that must be dropped.
      settle_down();
      write_waits(CSR_DATA_W'(2), CSR_DATA_W'(2), CSR_DATA_W'(2), CSR_DATA_W'(2));
      goal = done_seen + 1;
      push_tick(1'b1, $urandom, CNT_W'(8), 1'($urandom_range(1)));
      repeat (9) push_tick(1'b1, $urandom, CNT_W'($urandom_range(63)), 1'($urandom_range(1)));
      settle_down();
      write_reg(REG_PHASE, CSR_DATA_W'(0));
      write_reg(REG_POLARITY, CSR_DATA_W'(0));
      write_reg(REG_SAMPLE, CSR_DATA_W'(3));
      wait_done(goal, 1'b0);

      // Random part: four flow-control phases, fresh settings before each
      // transaction, noisy starts while busy.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 51; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 51; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
         endcase
         base = req_taken;
         while (req_taken - base < PHASE_TICKS) begin
            settle_down();
            write_reg(REG_POLARITY, CSR_DATA_W'($urandom_range(1)));
            write_reg(REG_PHASE, CSR_DATA_W'($urandom_range(1)));
            write_waits(pick_wait(), pick_wait(), pick_wait(), pick_wait());
            // Arm the long hold-off only once ticks are flowing.
            if (ph == 0) hold_armed = 1'b1;
            run_transfer($urandom, pick_count(), 1'b1);
         end
      end

      settle_down();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
